[sv/ghs_pkg.sv]
// Shared types, codes, constants and the exp table function for the heat map splatter.
package ghs_pkg;

   // Fixed-point limits of the exponent path
   localparam int unsigned LIMIT_Q16   = 301806;
   localparam int unsigned LIMIT1      = 301807;
   localparam int unsigned ONE_Q16     = 65536;
   localparam int unsigned RECIP_SHIFT = 24;
   localparam int unsigned Q_W         = 19;
   localparam int unsigned VALUE_W     = 17;

   // Queue depths
   localparam int unsigned REQ_QUEUE_DEPTH = 4;
   localparam int unsigned RSP_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_SPLAT = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_STRIDE = 2'd0,
      CSR_GRID_W = 2'd1,
      CSR_GRID_H = 2'd2,
      CSR_SIGMA  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_SPLAT,
      OP_READ,
      OP_DONE
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SPLAT,
      ST_DRAIN,
      ST_READ
   } state_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] kp_x;
      logic signed [15:0] kp_y;
      logic               available;
      logic               end_of_set;
      logic [11:0]        cell_index;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] cell_value;
      logic               done_res;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic signed [15:0] kp_x;
      logic signed [15:0] kp_y;
      logic               end_of_set;
      logic [11:0]        cell_index;
      logic               out_of_range;
   } op_word_type;

   typedef struct packed {
      logic [4:0]  stride;
      logic [6:0]  grid_w;
      logic [6:0]  grid_h;
      logic [15:0] sigma;
   } cfg_type;

   // exp(-x) for x in Q.16, result in unsigned Q1.16, by 16 squarings of (1 - x/2^16)
   function automatic logic [VALUE_W-1:0] exp_neg_q16(input logic [63:0] x);
      logic [63:0] b;
      logic [63:0] r;
      if (x == 64'd0) begin
         r = 64'(ONE_Q16);
      end else begin
         b = 64'h1_0000_0000 - x;
         for (int k = 0; k < 16; k++) begin
            b = (b * b + 64'h8000_0000) >> 32;
         end
         r = (b + 64'd32768) >> 16;
      end
      return r[VALUE_W-1:0];
   endfunction

endpackage

[sv/gaussian_heatmap_splat.sv]
// Top level of the gaussian heat map splatter: CSRs, queues, front and back ends.
//
// Request side is a queue: a word is taken when push is high and full is low.
// Result side is a queue: rsp_word is valid while empty is low, taken on pop.
// CSRs (stride, grid_w, grid_h, sigma) are written through csr_write/index/data,
// one write per cycle; the user must write them only while the block is idle,
// which the block itself does not enforce. After reset the map is cleared by a
// sweep of all MAX_GRID_W*MAX_GRID_H cells (4096 at default sizes); full stays
// high during that sweep. A clear command sweeps the map the same way, one cell
// per cycle. A splat streams one cell per cycle through a 26 stage pipeline (a
// 19 stage divider sets the depth); the heat map memory port, one read-modify-
// write per cycle, sets that rate. With the back end idle, an accepted read goes
// through the command queue, the registered memory read and the result queue
// before it is on the result ports.
// A splat with end_of_set gives a done word once every cell update is written.
// Commands are queued ahead of the back end, so requests keep being accepted
// while a result waits; when the result queue is full the back end stops
// before any read or done and resumes as soon as pop frees a slot.
module gaussian_heatmap_splat #(
   parameter int unsigned MAX_GRID_W = 64,
   parameter int unsigned MAX_GRID_H = 64,
   parameter int unsigned EXP_TABLE_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ghs_pkg::req_type req_word,
   output logic             empty,
   input  logic             pop,
   output ghs_pkg::rsp_type rsp_word,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);

   localparam int unsigned MAP_DEPTH = MAX_GRID_W * MAX_GRID_H;

   // configuration registers
   ghs_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stride <= 5'd8;
         cfg_ff.grid_w <= 7'd46;
         cfg_ff.grid_h <= 7'd46;
         cfg_ff.sigma  <= 16'd1792;
      end else if (csr_write) begin
         unique case (ghs_pkg::csr_index_type'(csr_index))
            ghs_pkg::CSR_STRIDE: cfg_ff.stride <= csr_data[4:0];
            ghs_pkg::CSR_GRID_W: cfg_ff.grid_w <= csr_data[6:0];
            ghs_pkg::CSR_GRID_H: cfg_ff.grid_h <= csr_data[6:0];
            ghs_pkg::CSR_SIGMA:  cfg_ff.sigma  <= csr_data;
         endcase
      end
   end

   logic                 init_busy;
   logic                 cq_full, cq_push, cq_empty, cq_pop;
   ghs_pkg::op_word_type cq_in_word, cq_out_word;
   logic                 rq_full, rq_push;
   ghs_pkg::rsp_type     rq_in_word;

   ghs_front #(
      .MAP_DEPTH(MAP_DEPTH)
   ) u_front (
      .req_word(req_word),
      .push(push),
      .full(full),
      .init_busy(init_busy),
      .q_full(cq_full),
      .q_push(cq_push),
      .q_word(cq_in_word)
   );

   ghs_fifo #(
      .DEPTH(ghs_pkg::REQ_QUEUE_DEPTH),
      .word_type(ghs_pkg::op_word_type)
   ) u_cmd_queue (
      .clock(clock),
      .reset(reset),
      .push(cq_push),
      .push_word(cq_in_word),
      .full(cq_full),
      .pop(cq_pop),
      .pop_word(cq_out_word),
      .empty(cq_empty)
   );

   ghs_back #(
      .MAX_GRID_W(MAX_GRID_W),
      .MAX_GRID_H(MAX_GRID_H),
      .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_empty(cq_empty),
      .q_word(cq_out_word),
      .q_pop(cq_pop),
      .rsp_full(rq_full),
      .rsp_push(rq_push),
      .rsp_word(rq_in_word),
      .init_busy(init_busy)
   );

   ghs_fifo #(
      .DEPTH(ghs_pkg::RSP_QUEUE_DEPTH),
      .word_type(ghs_pkg::rsp_type)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(rq_push),
      .push_word(rq_in_word),
      .full(rq_full),
      .pop(pop),
      .pop_word(rsp_word),
      .empty(empty)
   );

endmodule

[sv/ghs_fifo.sv]
// Small register queue used for the command and result words.
module ghs_fifo #(
   parameter int unsigned DEPTH = 2,
   parameter type word_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  word_type push_word,
   output logic     full,
   input  logic     pop,
   output word_type pop_word,
   output logic     empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   word_type        entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

[sv/ghs_front.sv]
// Front end: accepts request words, classifies them and queues the work.
module ghs_front #(
   parameter int unsigned MAP_DEPTH = 4096
) (
   input  ghs_pkg::req_type     req_word,
   input  logic                 push,
   output logic                 full,
   input  logic                 init_busy,
   input  logic                 q_full,
   output logic                 q_push,
   output ghs_pkg::op_word_type q_word
);

   logic keep;

   assign full = q_full || init_busy;

   // classify: drop unused codes and splats that do nothing
   always_comb begin
      keep              = 1'b0;
      q_word.op         = ghs_pkg::OP_CLEAR;
      q_word.kp_x       = req_word.kp_x;
      q_word.kp_y       = req_word.kp_y;
      q_word.end_of_set = req_word.end_of_set;
      q_word.cell_index = req_word.cell_index;
      q_word.out_of_range = (32'(req_word.cell_index) >= MAP_DEPTH);
      unique case (req_word.cmd)
         ghs_pkg::CMD_CLEAR: begin
            keep      = 1'b1;
            q_word.op = ghs_pkg::OP_CLEAR;
         end
         ghs_pkg::CMD_SPLAT: begin
            if (req_word.available) begin
               keep      = 1'b1;
               q_word.op = ghs_pkg::OP_SPLAT;
            end else if (req_word.end_of_set) begin
               keep      = 1'b1;
               q_word.op = ghs_pkg::OP_DONE;
            end
         end
         ghs_pkg::CMD_READ: begin
            keep      = 1'b1;
            q_word.op = ghs_pkg::OP_READ;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign q_push = push && !full && keep;

endmodule

[sv/ghs_expidx.sv]
// Cell pipeline: distance, pipelined divide by 2*sigma^2 and exp table index.
module ghs_expidx #(
   parameter int unsigned AW = 12,
   parameter int unsigned CXW = 16,
   parameter int unsigned EXP_TABLE_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [AW-1:0]                       in_addr,
   input  logic signed [CXW-1:0]               in_cx,
   input  logic signed [CXW-1:0]               in_cy,
   input  logic signed [15:0]                  kp_x,
   input  logic signed [15:0]                  kp_y,
   input  logic [31:0]                         s2,
   output logic                                out_valid,
   output logic                                out_ok,
   output logic [AW-1:0]                       out_addr,
   output logic [$clog2(EXP_TABLE_DEPTH)-1:0]  out_idx,
   output logic                                busy
);

   localparam int unsigned DXW = ((CXW > 16) ? CXW : 16) + 1;
   localparam int unsigned SQW = 2 * DXW - 1;
   localparam int unsigned IW  = $clog2(EXP_TABLE_DEPTH);
   localparam int unsigned QW  = ghs_pkg::Q_W;
   localparam int unsigned SH  = ghs_pkg::RECIP_SHIFT;
   localparam longint unsigned RECIP =
      ((64'd1 << SH) * EXP_TABLE_DEPTH) / ghs_pkg::LIMIT1;
   localparam int unsigned MW  = $clog2(RECIP + 1);
   localparam int unsigned PRW = QW + MW;
   localparam int unsigned CW  = QW + IW + 1;

   // stage 1: offsets from the keypoint
   logic signed [DXW-1:0] dx_in, dy_in;
   logic signed [DXW-1:0] dx1_ff, dy1_ff;
   logic                  v1_ff;
   logic [AW-1:0]         a1_ff;

   assign dx_in = DXW'(in_cx) - DXW'(kp_x);
   assign dy_in = DXW'(in_cy) - DXW'(kp_y);

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      dx1_ff <= dx_in;
      dy1_ff <= dy_in;
      a1_ff  <= in_addr;
   end

   // stage 2: squares
   logic signed [2*DXW-1:0] sqx_full, sqy_full;
   logic [SQW-1:0]          sqx2_ff, sqy2_ff;
   logic                    v2_ff;
   logic [AW-1:0]           a2_ff;

   assign sqx_full = dx1_ff * dx1_ff;
   assign sqy_full = dy1_ff * dy1_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      sqx2_ff <= sqx_full[SQW-1:0];
      sqy2_ff <= sqy_full[SQW-1:0];
      a2_ff   <= a1_ff;
   end

   // stage 3: d2 in Q.12, range check against s2 so the quotient fits QW bits
   logic [SQW:0]   d2;
   logic [SQW+4:0] r0;
   logic [31:0]    rem_ff [QW+1];
   logic [QW-1:0]  quo_ff [QW+1];
   logic           dv_ff  [QW+1];
   logic           dok_ff [QW+1];
   logic [AW-1:0]  dad_ff [QW+1];

   assign d2 = {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
   assign r0 = {d2, 4'b0000};

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else       dv_ff[0] <= v2_ff;
   end
   always_ff @(posedge clock) begin
      rem_ff[0] <= r0[31:0];
      quo_ff[0] <= '0;
      dok_ff[0] <= (r0 < (SQW+5)'(s2));
      dad_ff[0] <= a2_ff;
   end

   // restoring divider, one quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [32:0] t;
      logic [32:0] diff;
      logic        ge;

      assign t    = {rem_ff[k], 1'b0};
      assign diff = t - {1'b0, s2};
      assign ge   = (t >= {1'b0, s2});

      always_ff @(posedge clock) begin
         if (reset) dv_ff[k+1] <= 1'b0;
         else       dv_ff[k+1] <= dv_ff[k];
      end
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge ? diff[31:0] : t[31:0];
         quo_ff[k+1] <= {quo_ff[k][QW-2:0], ge};
         dok_ff[k+1] <= dok_ff[k];
         dad_ff[k+1] <= dad_ff[k];
      end
   end

   // stage 4: cut-off and reciprocal product for the table index
   logic [QW-1:0]  e;
   logic [PRW-1:0] prod4_ff;
   logic [QW-1:0]  e4_ff;
   logic           v4_ff, ok4_ff;
   logic [AW-1:0]  a4_ff;

   assign e = quo_ff[QW];

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= dv_ff[QW];
   end
   always_ff @(posedge clock) begin
      prod4_ff <= PRW'(e) * PRW'(RECIP);
      e4_ff    <= e;
      ok4_ff   <= dok_ff[QW] && (32'(e) <= ghs_pkg::LIMIT_Q16);
      a4_ff    <= dad_ff[QW];
   end

   // stage 5: estimate may be one low, form both sides of the correction test
   logic [IW-1:0] est;
   logic [IW:0]   est_p1;
   logic [IW-1:0] est5_ff;
   logic [CW-1:0] t5_ff, ed5_ff;
   logic          v5_ff, ok5_ff;
   logic [AW-1:0] a5_ff;

   assign est    = IW'(prod4_ff >> SH);
   assign est_p1 = {1'b0, est} + (IW+1)'(1);

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
   end
   always_ff @(posedge clock) begin
      est5_ff <= est;
      t5_ff   <= CW'(est_p1) * CW'(ghs_pkg::LIMIT1);
      ed5_ff  <= CW'(e4_ff) * CW'(EXP_TABLE_DEPTH);
      ok5_ff  <= ok4_ff;
      a5_ff   <= a4_ff;
   end

   // stage 6: corrected and clamped index
   logic [IW:0]   idx_wide;
   logic [IW-1:0] idx6_ff;
   logic          v6_ff, ok6_ff;
   logic [AW-1:0] a6_ff;

   assign idx_wide = (t5_ff <= ed5_ff) ? ({1'b0, est5_ff} + (IW+1)'(1)) : {1'b0, est5_ff};

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else       v6_ff <= v5_ff;
   end
   always_ff @(posedge clock) begin
      idx6_ff <= (32'(idx_wide) >= EXP_TABLE_DEPTH) ? IW'(EXP_TABLE_DEPTH - 1)
                                                   : idx_wide[IW-1:0];
      ok6_ff  <= ok5_ff;
      a6_ff   <= a5_ff;
   end

   assign out_valid = v6_ff;
   assign out_ok    = ok6_ff;
   assign out_addr  = a6_ff;
   assign out_idx   = idx6_ff;

   // any cell still in flight
   always_comb begin
      busy = v1_ff || v2_ff || v4_ff || v5_ff || v6_ff;
      for (int k = 0; k <= QW; k++) begin
         busy = busy || dv_ff[k];
      end
   end

endmodule

[sv/ghs_back.sv]
// Back end: command sequencer, heat map memory, exp table and cell update.
module ghs_back #(
   parameter int unsigned MAX_GRID_W = 64,
   parameter int unsigned MAX_GRID_H = 64,
   parameter int unsigned EXP_TABLE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ghs_pkg::cfg_type     cfg,
   input  logic                 q_empty,
   input  ghs_pkg::op_word_type q_word,
   output logic                 q_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output ghs_pkg::rsp_type     rsp_word,
   output logic                 init_busy
);

   localparam int unsigned MAP_DEPTH = MAX_GRID_W * MAX_GRID_H;
   localparam int unsigned AW   = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int unsigned GWW  = $clog2(MAX_GRID_W + 1);
   localparam int unsigned GHW  = $clog2(MAX_GRID_H + 1);
   localparam int unsigned MAXG = (MAX_GRID_W > MAX_GRID_H) ? MAX_GRID_W : MAX_GRID_H;
   localparam int unsigned CX_MAX = 31 * 8 + (MAXG - 1) * 31 * 16;
   localparam int unsigned CXW  = $clog2(CX_MAX + 1) + 1;
   localparam int unsigned IW   = $clog2(EXP_TABLE_DEPTH);
   localparam int unsigned VW   = ghs_pkg::VALUE_W;

   ghs_pkg::state_type state_ff, state_in;

   logic [AW-1:0]         sweep_ff;
   logic [GWW-1:0]        gx_ff, gw_ff;
   logic [GHW-1:0]        gy_ff, gh_ff;
   logic [AW-1:0]         addr_ff;
   logic signed [CXW-1:0] cx_ff, cy_ff, start_ff, step_ff;
   logic [31:0]           s2_ff;
   logic signed [15:0]    kx_ff, ky_ff;
   logic                  eos_ff;
   logic                  oob_ff;

   // splat setup values from the configuration
   logic [15:0]           sigma_eff;
   logic [31:0]           s2_val;
   logic [GWW-1:0]        gw_eff;
   logic [GHW-1:0]        gh_eff;
   logic signed [CXW-1:0] start_val, step_val;
   logic                  grid_zero;

   assign sigma_eff = (cfg.sigma == 16'd0) ? 16'd1 : cfg.sigma;
   assign s2_val    = 32'(sigma_eff) * 32'(sigma_eff);
   assign gw_eff    = (32'(cfg.grid_w) > MAX_GRID_W) ? GWW'(MAX_GRID_W) : GWW'(cfg.grid_w);
   assign gh_eff    = (32'(cfg.grid_h) > MAX_GRID_H) ? GHW'(MAX_GRID_H) : GHW'(cfg.grid_h);
   assign start_val = CXW'({cfg.stride, 3'b000}) - CXW'(8);
   assign step_val  = CXW'({cfg.stride, 4'b0000});
   assign grid_zero = (gw_eff == '0) || (gh_eff == '0);

   // cell scan position
   logic last_col, last_cell, sweep_last;

   assign last_col   = (gx_ff == gw_ff - GWW'(1));
   assign last_cell  = last_col && (gy_ff == gh_ff - GHW'(1));
   assign sweep_last = (sweep_ff == AW'(MAP_DEPTH - 1));

   // cell pipeline
   logic          pipe_valid, pipe_ok, pipe_busy;
   logic [AW-1:0] pipe_addr;
   logic [IW-1:0] pipe_idx;
   logic          cell_issue;

   ghs_expidx #(
      .AW(AW),
      .CXW(CXW),
      .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
   ) u_expidx (
      .clock(clock),
      .reset(reset),
      .in_valid(cell_issue),
      .in_addr(addr_ff),
      .in_cx(cx_ff),
      .in_cy(cy_ff),
      .kp_x(kx_ff),
      .kp_y(ky_ff),
      .s2(s2_ff),
      .out_valid(pipe_valid),
      .out_ok(pipe_ok),
      .out_addr(pipe_addr),
      .out_idx(pipe_idx),
      .busy(pipe_busy)
   );

   // exp table, built at elaboration
   logic [VW-1:0] exp_rom [EXP_TABLE_DEPTH];

   for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_rom
      assign exp_rom[i] = ghs_pkg::exp_neg_q16(
         64'((64'(i) * 64'(ghs_pkg::LIMIT1)) / EXP_TABLE_DEPTH));
   end

   // update stage: table value and old cell value arrive together
   logic [VW-1:0] rom_q_ff, mem_q_ff;
   logic          v7_ff, ok7_ff;
   logic [AW-1:0] a7_ff;
   logic [VW:0]   sum;
   logic [VW-1:0] sum_sat;
   logic          busy_all;

   assign sum      = {1'b0, mem_q_ff} + {1'b0, rom_q_ff};
   assign sum_sat  = (32'(sum) > ghs_pkg::ONE_Q16) ? VW'(ghs_pkg::ONE_Q16) : sum[VW-1:0];
   assign busy_all = pipe_busy || v7_ff;

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else       v7_ff <= pipe_valid;
   end
   always_ff @(posedge clock) begin
      rom_q_ff <= exp_rom[pipe_idx];
      ok7_ff   <= pipe_ok;
      a7_ff    <= pipe_addr;
   end

   // sequencer controls
   logic start_splat, start_sweep, read_issue, sweep_we, drain_exit;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ghs_pkg::ST_INIT: begin
            if (sweep_last) state_in = ghs_pkg::ST_IDLE;
         end
         ghs_pkg::ST_IDLE: begin
            if (!q_empty) begin
               unique case (q_word.op)
                  ghs_pkg::OP_CLEAR: state_in = ghs_pkg::ST_CLEAR;
                  ghs_pkg::OP_SPLAT: begin
                     state_in = grid_zero ? ghs_pkg::ST_DRAIN : ghs_pkg::ST_SPLAT;
                  end
                  ghs_pkg::OP_READ: begin
                     if (!rsp_full) state_in = ghs_pkg::ST_READ;
                  end
                  ghs_pkg::OP_DONE: state_in = ghs_pkg::ST_IDLE;
               endcase
            end
         end
         ghs_pkg::ST_CLEAR: begin
            if (sweep_last) state_in = ghs_pkg::ST_IDLE;
         end
         ghs_pkg::ST_SPLAT: begin
            if (last_cell) state_in = ghs_pkg::ST_DRAIN;
         end
         ghs_pkg::ST_DRAIN: begin
            if (drain_exit) state_in = ghs_pkg::ST_IDLE;
         end
         ghs_pkg::ST_READ: state_in = ghs_pkg::ST_IDLE;
         default: state_in = ghs_pkg::ST_IDLE;
      endcase
   end

   assign drain_exit = !busy_all && (!eos_ff || !rsp_full);

   always_comb begin
      q_pop       = 1'b0;
      rsp_push    = 1'b0;
      start_splat = 1'b0;
      start_sweep = 1'b0;
      read_issue  = 1'b0;
      sweep_we    = 1'b0;
      cell_issue  = 1'b0;
      rsp_word.cell_value = '0;
      rsp_word.done_res   = 1'b1;
      unique case (state_ff)
         ghs_pkg::ST_INIT: begin
            sweep_we = 1'b1;
         end
         ghs_pkg::ST_IDLE: begin
            if (!q_empty) begin
               unique case (q_word.op)
                  ghs_pkg::OP_CLEAR: begin
                     q_pop       = 1'b1;
                     start_sweep = 1'b1;
                  end
                  ghs_pkg::OP_SPLAT: begin
                     q_pop       = 1'b1;
                     start_splat = 1'b1;
                  end
                  ghs_pkg::OP_READ: begin
                     q_pop      = !rsp_full;
                     read_issue = !rsp_full;
                  end
                  ghs_pkg::OP_DONE: begin
                     q_pop    = !rsp_full;
                     rsp_push = !rsp_full;
                  end
               endcase
            end
         end
         ghs_pkg::ST_CLEAR: begin
            sweep_we = 1'b1;
         end
         ghs_pkg::ST_SPLAT: begin
            cell_issue = 1'b1;
         end
         ghs_pkg::ST_DRAIN: begin
            rsp_push = drain_exit && eos_ff;
         end
         ghs_pkg::ST_READ: begin
            rsp_push            = 1'b1;
            rsp_word.cell_value = oob_ff ? '0 : mem_q_ff;
            rsp_word.done_res   = 1'b0;
         end
         default: begin
            rsp_push = 1'b0;
         end
      endcase
   end

   assign init_busy = (state_ff == ghs_pkg::ST_INIT);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ghs_pkg::ST_INIT;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (start_sweep) sweep_ff <= '0;
         else if (sweep_we) sweep_ff <= sweep_last ? '0 : sweep_ff + AW'(1);
      end
   end

   // scan counters and splat setup
   always_ff @(posedge clock) begin
      if (start_splat) begin
         gx_ff    <= '0;
         gy_ff    <= '0;
         addr_ff  <= '0;
         gw_ff    <= gw_eff;
         gh_ff    <= gh_eff;
         cx_ff    <= start_val;
         cy_ff    <= start_val;
         start_ff <= start_val;
         step_ff  <= step_val;
         s2_ff    <= s2_val;
         kx_ff    <= q_word.kp_x;
         ky_ff    <= q_word.kp_y;
         eos_ff   <= q_word.end_of_set;
      end else if (cell_issue) begin
         addr_ff <= addr_ff + AW'(1);
         if (last_col) begin
            gx_ff <= '0;
            cx_ff <= start_ff;
            gy_ff <= gy_ff + GHW'(1);
            cy_ff <= cy_ff + step_ff;
         end else begin
            gx_ff <= gx_ff + GWW'(1);
            cx_ff <= cx_ff + step_ff;
         end
      end
      if (read_issue) oob_ff <= q_word.out_of_range;
   end

   // heat map memory: one write port, one registered read port
   logic [VW-1:0] heat_mem [MAP_DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [VW-1:0] mem_wdata;

   assign mem_we    = sweep_we || (v7_ff && ok7_ff);
   assign mem_waddr = sweep_we ? sweep_ff : a7_ff;
   assign mem_wdata = sweep_we ? '0 : sum_sat;
   assign mem_raddr = read_issue ? AW'(q_word.cell_index) : pipe_addr;

   always_ff @(posedge clock) begin
      if (mem_we) heat_mem[mem_waddr] <= mem_wdata;
      mem_q_ff <= heat_mem[mem_raddr];
   end

endmodule
